// ===== sv/pspd_pkg.sv =====
// Shared types, codes and constants of the pollution sampling predictor.
package pspd_pkg;

  localparam int CONTEXTS_DEF = 64;
  localparam int CONTEXT_ID_W = 6;
  localparam int CONTEXT_IDS  = 2 ** CONTEXT_ID_W;
  localparam int SIZE_W       = 32;
  localparam int REFS_W       = 32;
  localparam int RATIO_W      = 17;
  localparam int SKIP_W       = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int DIV_STEPS    = 16;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  localparam logic [SIZE_W-1:0]  SMALL_CHUNK_RST = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0]  LARGE_CHUNK_RST = SIZE_W'(1048576);
  localparam logic [RATIO_W-1:0] THRESHOLD_RST   = RATIO_W'(32768);
  localparam logic [SKIP_W-1:0]  MAX_SKIP_RST    = SKIP_W'(32768);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_MONITOR = 1'b1
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SMALL_CHUNK = 2'd0,
    REG_LARGE_CHUNK = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_MAX_SKIP    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN    = 2'd0,
    TYPE_OPEN       = 2'd1,
    TYPE_RESTRICTED = 2'd2
  } chunk_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  // One prediction record per context; all-zero is the reset value.
  typedef struct packed {
    logic [SIZE_W-1:0]  last_size;
    logic [SKIP_W-1:0]  skip_left;
    logic [SKIP_W-1:0]  skip_period;
    chunk_type_e        older_type;
    chunk_type_e        newer_type;
    logic [RATIO_W-1:0] older_ratio;
    logic               older_valid;
    logic [RATIO_W-1:0] newer_ratio;
    logic               newer_valid;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic clear;
    logic alloc_fin;
    logic div_start;
    logic div_step;
    logic mon_fin;
  } cmd_t;

  typedef struct packed {
    logic is_monitor;
    logic clr_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/pspd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pspd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pspd_ctrl.sv =====
// Controller state machine: clearing pass, table read, divide and write-back sequencing.
module pspd_ctrl
  import pspd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.is_monitor) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (sts_i.out_free) begin
          cmd_o.alloc_fin = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.mon_fin = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/pspd_dpath.sv =====
// Datapath: configuration registers, prediction table, ratio divider and output register.
module pspd_dpath
  import pspd_pkg::*;
#(
  parameter int CONTEXTS = CONTEXTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    op_i,
  input  logic [CONTEXT_ID_W-1:0] context_id_i,
  input  logic [SIZE_W-1:0]       size_i,
  input  logic                    chunk_mapping_i,
  input  logic [REFS_W-1:0]       pollutor_refs_i,
  input  logic [REFS_W-1:0]       total_refs_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    monitored_o,
  output logic                    realign_o,
  output logic [RATIO_W-1:0]      ratio_o,
  output logic                    ratio_valid_o,
  output logic                    mapping_o
);

  localparam int AW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int REC_W = $bits(rec_t);

  // configuration
  logic [SIZE_W-1:0]  small_q, large_q;
  logic [RATIO_W-1:0] thresh_q;
  logic [SKIP_W-1:0]  max_skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q    <= SMALL_CHUNK_RST;
      large_q    <= LARGE_CHUNK_RST;
      thresh_q   <= THRESHOLD_RST;
      max_skip_q <= MAX_SKIP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SMALL_CHUNK: small_q    <= cfg_data_i[SIZE_W-1:0];
        REG_LARGE_CHUNK: large_q    <= cfg_data_i[SIZE_W-1:0];
        REG_THRESHOLD:   thresh_q   <= cfg_data_i[RATIO_W-1:0];
        REG_MAX_SKIP:    max_skip_q <= cfg_data_i[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // context id folded onto the table depth
  logic [AW-1:0] ctx_map [CONTEXT_IDS];
  for (genvar g = 0; g < CONTEXT_IDS; g++) begin : g_ctx_map
    assign ctx_map[g] = AW'(g % CONTEXTS);
  end

  // captured word
  logic                op_q, given_q;
  logic [AW-1:0]       ctx_q;
  logic [SIZE_W-1:0]   size_q;
  logic                lt_large_q, lt_small_q, tot0_q, sat_q;
  logic [REFS_W-1:0]   tot_q;
  logic [REFS_W-1:0]   rem_q, rem_d;
  logic [SKIP_W-1:0]   quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [REFS_W:0]     rem_sh;
  logic                rem_ge;

  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, tot_q};
  assign rem_d  = rem_ge ? REFS_W'(rem_sh - {1'b0, tot_q}) : rem_sh[REFS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      given_q    <= chunk_mapping_i;
      ctx_q      <= ctx_map[context_id_i];
      size_q     <= size_i;
      lt_large_q <= size_i < large_q;
      lt_small_q <= size_i < small_q;
      tot0_q     <= total_refs_i == '0;
      sat_q      <= pollutor_refs_i >= total_refs_i;
      tot_q      <= total_refs_i;
      rem_q      <= pollutor_refs_i;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SKIP_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_q;
  logic          clr_last;

  assign clr_last = clr_q == AW'(CONTEXTS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !clr_last) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // table
  rec_t             rec, alloc_rec, mon_rec;
  logic [REC_W-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]    ram_waddr;
  logic             ram_we;

  assign rec       = rec_t'(ram_rdata);
  assign ram_we    = cmd_i.clear | cmd_i.alloc_fin | cmd_i.mon_fin;
  assign ram_waddr = cmd_i.clear ? clr_q : ctx_q;
  assign ram_wdata = cmd_i.clear ? '0 : (cmd_i.mon_fin ? REC_W'(mon_rec) : REC_W'(alloc_rec));

  pspd_ram #(
    .WIDTH (REC_W),
    .DEPTH (CONTEXTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (ctx_q),
    .rdata_o (ram_rdata)
  );

  // allocation update
  logic               skip;
  logic [RATIO_W-1:0] pred_ratio;
  logic               pred_valid;

  assign skip = (rec.skip_left != '0) && (rec.last_size == size_q) && lt_large_q;

  always_comb begin
    if (!rec.older_valid) begin
      pred_valid = rec.newer_valid;
      pred_ratio = rec.newer_valid ? rec.newer_ratio : '0;
    end else if (rec.newer_valid) begin
      pred_valid = 1'b1;
      pred_ratio = (rec.older_ratio < rec.newer_ratio) ? rec.older_ratio : rec.newer_ratio;
    end else begin
      pred_valid = 1'b1;
      pred_ratio = rec.older_ratio;
    end
  end

  always_comb begin
    alloc_rec = rec;
    if (skip) begin
      alloc_rec.skip_left = rec.skip_left - SKIP_W'(1);
    end else begin
      // size changed: drop the older history entry and the interval
      if (rec.last_size != size_q) begin
        alloc_rec.skip_period = '0;
        alloc_rec.older_type  = TYPE_UNKNOWN;
        alloc_rec.older_valid = 1'b0;
        alloc_rec.older_ratio = '0;
      end
      if (rec.skip_left == '0 && lt_large_q) begin
        alloc_rec.skip_left = alloc_rec.skip_period;
      end
      alloc_rec.last_size = size_q;
    end
  end

  // monitoring update
  logic [RATIO_W-1:0] meas;
  logic               cls;
  logic [SKIP_W:0]    grown;
  logic [SKIP_W-1:0]  grown_sat;

  assign meas      = tot0_q ? '0 : (sat_q ? RATIO_ONE : {1'b0, quo_q});
  assign cls       = meas >= thresh_q;
  assign grown     = (rec.skip_period == '0) ? (SKIP_W + 1)'(1) : {rec.skip_period, 1'b0};
  assign grown_sat = (grown > {1'b0, max_skip_q}) ? max_skip_q : grown[SKIP_W-1:0];

  always_comb begin
    mon_rec             = rec;
    mon_rec.older_type  = rec.newer_type;
    mon_rec.newer_type  = cls ? TYPE_RESTRICTED : TYPE_OPEN;
    mon_rec.older_ratio = rec.newer_ratio;
    mon_rec.older_valid = rec.newer_valid;
    mon_rec.newer_ratio = meas;
    mon_rec.newer_valid = 1'b1;
    if (lt_large_q) begin
      mon_rec.skip_period = (cls != given_q) ? '0 : grown_sat;
      mon_rec.skip_left   = mon_rec.skip_period;
    end
  end

  // output register
  logic               out_valid_q;
  logic               monitored_q, realign_q, ratio_valid_q, mapping_q;
  logic [RATIO_W-1:0] ratio_q;
  logic               out_free, out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.alloc_fin | cmd_i.mon_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_fin) begin
      monitored_q   <= !skip;
      realign_q     <= !skip && lt_small_q;
      ratio_q       <= skip ? '0 : pred_ratio;
      ratio_valid_q <= !skip && pred_valid;
      mapping_q     <= (alloc_rec.older_type == TYPE_RESTRICTED) &&
                       (alloc_rec.newer_type == TYPE_RESTRICTED);
    end else if (cmd_i.mon_fin) begin
      monitored_q   <= 1'b0;
      realign_q     <= 1'b0;
      ratio_q       <= meas;
      ratio_valid_q <= 1'b1;
      mapping_q     <= cls;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign monitored_o   = monitored_q;
  assign realign_o     = realign_q;
  assign ratio_o       = ratio_q;
  assign ratio_valid_o = ratio_valid_q;
  assign mapping_o     = mapping_q;

  assign sts_o.is_monitor = op_q == OP_MONITOR;
  assign sts_o.clr_last   = clr_last;
  assign sts_o.div_last   = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts_o.out_free   = out_free;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over an untaken word");

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !(cmd_i.alloc_fin || cmd_i.mon_fin || cmd_i.capture))
    else $error("table write or capture during clearing pass");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ratio_q <= RATIO_ONE)
    else $error("ratio above one");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ratio_valid_q) |-> ratio_q == '0)
    else $error("invalid ratio is not zero");

endmodule

// ===== sv/pollution_sampling_predictor_top.sv =====
// Allocation: capture, table read, then the result loads once the output register is free.
// Monitoring: capture, table read, then the 16-step restoring ratio divider (one bit a cycle),
// then the result waits for a free output register; a new word is taken only after each result.
// One word is in flight at a time; a finished result waits in the output register.
// After reset a clearing pass writes every table entry, with in_stall_o high;
// configuration writes are taken at all times and registers reset to their defaults.
module pollution_sampling_predictor_top
  import pspd_pkg::*;
#(
  parameter int CONTEXTS = CONTEXTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [CONTEXT_ID_W-1:0] context_id_i,
  input  logic [SIZE_W-1:0]       size_i,
  input  logic                    chunk_mapping_i,
  input  logic [REFS_W-1:0]       pollutor_refs_i,
  input  logic [REFS_W-1:0]       total_refs_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    monitored_o,
  output logic                    realign_o,
  output logic [RATIO_W-1:0]      ratio_o,
  output logic                    ratio_valid_o,
  output logic                    mapping_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pspd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pspd_dpath #(
    .CONTEXTS (CONTEXTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .context_id_i    (context_id_i),
    .size_i          (size_i),
    .chunk_mapping_i (chunk_mapping_i),
    .pollutor_refs_i (pollutor_refs_i),
    .total_refs_i    (total_refs_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .monitored_o     (monitored_o),
    .realign_o       (realign_o),
    .ratio_o         (ratio_o),
    .ratio_valid_o   (ratio_valid_o),
    .mapping_o       (mapping_o)
  );

endmodule
